@@ sv/tdve_pkg.sv @@
// Shared types and constants for the timestamp delta-of-delta varint encoder.
package tdve_pkg;

  localparam int unsigned TS_W = 64;
  localparam int unsigned RAW_BYTES = 8;
  localparam int unsigned MAX_VARINT_BYTES = 10;
  localparam int unsigned CNT_W = 4;
  localparam logic [7:0] CONT_BIT = 8'h80;
  localparam logic [CNT_W-1:0] RAW_LAST_IDX = CNT_W'(RAW_BYTES - 1);
  localparam logic [CNT_W-1:0] VARINT_LAST_IDX = CNT_W'(MAX_VARINT_BYTES - 1);

  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_MANY = 2'd2
  } seen_t;

  typedef struct packed {
    logic signed [TS_W-1:0] timestamp;
    logic                   first_of_series;
  } ts_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } byte_item_t;

  // One queued job: either a raw big-endian delta or a zigzag value for varint coding.
  typedef struct packed {
    logic            raw;
    logic [TS_W-1:0] value;
  } job_t;

  function automatic logic [TS_W-1:0] zigzag(input logic [TS_W-1:0] d);
    zigzag = {d[TS_W-2:0], 1'b0} ^ {TS_W{d[TS_W-1]}};
  endfunction

endpackage

@@ sv/tdve_front.sv @@
// Front end: accepts timestamps, tracks series history and classifies each item into a job.
module tdve_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              ts_valid,
  input  tdve_pkg::ts_item_t ts_item,
  input  logic              q_full,
  output logic              ts_stall,
  output logic              push,
  output tdve_pkg::job_t    job
);

  tdve_pkg::seen_t seen, seen_next;
  logic [tdve_pkg::TS_W-1:0] prev_ts, prev_ts_next;
  // Predicted timestamp: previous timestamp plus previous delta.
  logic [tdve_pkg::TS_W-1:0] pred, pred_next;
  logic [tdve_pkg::TS_W-1:0] ts;
  logic [tdve_pkg::TS_W-1:0] delta;
  logic [tdve_pkg::TS_W-1:0] dod;
  logic accept;
  logic start;

  assign ts       = ts_item.timestamp;
  assign ts_stall = q_full;
  assign accept   = ts_valid && !ts_stall;
  assign start    = ts_item.first_of_series || (seen == tdve_pkg::SEEN_NONE);
  assign delta    = ts - prev_ts;
  assign dod      = ts - pred;

  always_comb begin
    seen_next    = seen;
    prev_ts_next = prev_ts;
    pred_next    = pred;
    push         = 1'b0;
    job.raw      = (seen == tdve_pkg::SEEN_ONE);
    job.value    = job.raw ? delta : tdve_pkg::zigzag(dod);
    if (accept) begin
      prev_ts_next = ts;
      if (start) begin
        seen_next = tdve_pkg::SEEN_ONE;
        pred_next = ts;
      end else begin
        seen_next = tdve_pkg::SEEN_MANY;
        // ts + (ts - prev_ts) in a single subtract.
        pred_next = {ts[tdve_pkg::TS_W-2:0], 1'b0} - prev_ts;
        push      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= tdve_pkg::SEEN_NONE;
      prev_ts <= '0;
      pred    <= '0;
    end else begin
      seen    <= seen_next;
      prev_ts <= prev_ts_next;
      pred    <= pred_next;
    end
  end

endmodule

@@ sv/tdve_queue.sv @@
// Short job queue between the front end and the byte generator.
module tdve_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tdve_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output tdve_pkg::job_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tdve_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

@@ sv/tdve_back.sv @@
// Back end: expands queued jobs into output bytes through a registered output stage.
module tdve_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  tdve_pkg::job_t      q_head,
  output logic                pop,
  output logic                byte_valid,
  input  logic                byte_stall,
  output tdve_pkg::byte_item_t byte_item
);

  logic                          busy;
  logic                          raw;
  logic [tdve_pkg::TS_W-1:0]     work;
  logic [tdve_pkg::CNT_W-1:0]    cnt;
  logic [7:0]                    gen_byte;
  logic                          gen_last;
  logic [tdve_pkg::TS_W-1:0]     work_next;
  logic                          more;
  logic                          adv;
  logic                          take;

  always_comb begin
    more = 1'b0;
    if (raw) begin
      gen_byte  = work[tdve_pkg::TS_W-1 -: 8];
      gen_last  = (cnt == tdve_pkg::RAW_LAST_IDX);
      work_next = work << 8;
    end else begin
      // The tenth byte carries whatever bit remains, so stop continuing there.
      more      = (|work[tdve_pkg::TS_W-1:7]) && (cnt != tdve_pkg::VARINT_LAST_IDX);
      gen_byte  = more ? (tdve_pkg::CONT_BIT | {1'b0, work[6:0]}) : work[7:0];
      gen_last  = !more;
      work_next = work >> 7;
    end
  end

  assign take = byte_valid && !byte_stall;
  assign adv  = busy && (!byte_valid || !byte_stall);
  assign pop  = !q_empty && (!busy || (adv && gen_last));

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_item.out_byte    <= gen_byte;
      byte_item.last_of_run <= gen_last;
    end
    if (pop) begin
      raw  <= q_head.raw;
      work <= q_head.value;
    end else if (adv) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cnt        <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (adv) begin
        byte_valid <= 1'b1;
      end else if (take) begin
        byte_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (adv) begin
        busy <= !gen_last;
        cnt  <= cnt + tdve_pkg::CNT_W'(1);
      end
    end
  end

  a_raw_len: assert property (@(posedge clk) disable iff (rst)
    (busy && raw) |-> (cnt <= tdve_pkg::RAW_LAST_IDX))
    else $error("raw delta ran past eight bytes");
  a_varint_len: assert property (@(posedge clk) disable iff (rst)
    (busy && !raw) |-> (cnt <= tdve_pkg::VARINT_LAST_IDX))
    else $error("varint ran past ten bytes");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && busy) |-> (adv && gen_last))
    else $error("new job loaded over an unfinished one");

endmodule

@@ sv/timestamp_dod_varint_encoder_core.sv @@
// Timestamp delta-of-delta encoder: a front end, a job queue and a byte generator.
//
// Input channel (ts_valid, ts_stall, ts_item) takes one signed 64-bit timestamp per
// item plus a first_of_series flag. Output channel (byte_valid, byte_stall, byte_item)
// delivers the encoded bytes; last_of_run marks the final byte of each input item.
// The first item of a series produces no bytes, the second produces its delta as eight
// bytes most significant first, and later items produce a zigzag varint of the
// delta-of-delta, one to ten bytes.
// An item's job passes through the job queue and the byte generator's work register
// to the output register. Throughput: while byte_stall is low the generator emits one
// byte per cycle; with one-byte varints the block then takes one item per cycle.
// The job queue of QUEUE_DEPTH entries lets the front end keep taking items while a
// long run is being emitted; ts_stall rises only when the queue is full.
// When byte_stall is high the output register holds its byte and the generator waits;
// the queue then fills and the stall reaches the input side.
// Reset clears the series history, the queue and the output stage; the first item after
// reset starts a series whether or not its flag is set.
module timestamp_dod_varint_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ts_valid,
  output logic                 ts_stall,
  input  tdve_pkg::ts_item_t   ts_item,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output tdve_pkg::byte_item_t byte_item
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  tdve_pkg::job_t push_job;
  tdve_pkg::job_t q_head;

  tdve_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ts_valid (ts_valid),
    .ts_item  (ts_item),
    .q_full   (q_full),
    .ts_stall (ts_stall),
    .push     (push),
    .job      (push_job)
  );

  tdve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  tdve_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the timestamp delta-of-delta varint encoder core.
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic signed [tdve_pkg::TS_W-1:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [tdve_pkg::TS_W-1:0] TS_MIN = 64'sh8000_0000_0000_0000;
  localparam int USE_PREDICTOR = -1;

  // One directed item; when n_bytes is not USE_PREDICTOR the expected bytes are
  // written out by hand, left-justified, first byte in bits 79:72.
  typedef struct {
    logic signed [tdve_pkg::TS_W-1:0] ts;
    logic                             first;
    int                               n_bytes;
    logic [79:0]                      bytes;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ts_valid = 1'b0;
  logic ts_stall;
  tdve_pkg::ts_item_t ts_item = '0;
  logic byte_valid;
  logic byte_stall = 1'b0;
  tdve_pkg::byte_item_t byte_item;

  // Predictor state.
  tdve_pkg::seen_t series_seen = tdve_pkg::SEEN_NONE;
  logic [tdve_pkg::TS_W-1:0] last_ts = '0;
  logic [tdve_pkg::TS_W-1:0] last_delta = '0;
  tdve_pkg::byte_item_t run_bytes[$];
  tdve_pkg::byte_item_t expected_bytes[$];

  // Stimulus generator state.
  logic [tdve_pkg::TS_W-1:0] gen_ts = '0;
  logic [tdve_pkg::TS_W-1:0] gen_period = 64'd10;
  int series_left = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  timestamp_dod_varint_encoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .ts_valid  (ts_valid),
    .ts_stall  (ts_stall),
    .ts_item   (ts_item),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fills run_bytes with the bytes one timestamp produces and advances the history.
  function automatic void encode_timestamp(input tdve_pkg::ts_item_t it);
    logic [tdve_pkg::TS_W-1:0] delta;
    logic [tdve_pkg::TS_W-1:0] dod;
    logic [tdve_pkg::TS_W-1:0] zz;
    run_bytes.delete();
    if (it.first_of_series || series_seen == tdve_pkg::SEEN_NONE) begin
      series_seen = tdve_pkg::SEEN_ONE;
      last_ts = it.timestamp;
      last_delta = '0;
      return;
    end
    delta = it.timestamp - last_ts;
    last_ts = it.timestamp;
    if (series_seen == tdve_pkg::SEEN_ONE) begin
      for (int b = tdve_pkg::RAW_BYTES - 1; b >= 0; b--) begin
        run_bytes.insert(run_bytes.size(),
                         tdve_pkg::byte_item_t'{delta[8*b +: 8], 1'(b == 0)});
      end
      last_delta = delta;
      series_seen = tdve_pkg::SEEN_MANY;
      return;
    end
    dod = delta - last_delta;
    last_delta = delta;
    zz = {dod[tdve_pkg::TS_W-2:0], 1'b0} ^ {tdve_pkg::TS_W{dod[tdve_pkg::TS_W-1]}};
    while (zz >= 64'(tdve_pkg::CONT_BIT) &&
           run_bytes.size() < tdve_pkg::MAX_VARINT_BYTES - 1) begin
      run_bytes.insert(run_bytes.size(),
                       tdve_pkg::byte_item_t'{tdve_pkg::CONT_BIT | {1'b0, zz[6:0]}, 1'b0});
      zz = zz >> 7;
    end
    run_bytes.insert(run_bytes.size(), tdve_pkg::byte_item_t'{zz[7:0] & 8'hFF, 1'b1});
  endfunction

  // Mostly regular series with jitter, some wide deltas, full-range noise and
  // series cut short by an early start flag.
  function automatic tdve_pkg::ts_item_t random_item();
    tdve_pkg::ts_item_t it;
    int unsigned pick;
    logic [tdve_pkg::TS_W-1:0] wide;
    pick = $urandom_range(99);
    it.first_of_series = 1'b0;
    if (series_left == 0 || pick < 4) begin
      it.first_of_series = 1'b1;
      it.timestamp = {$urandom, $urandom};
      series_left = $urandom_range(30, 1);
      if ($urandom_range(3) == 0) gen_period = {$urandom, $urandom} >> $urandom_range(63);
      else gen_period = 64'($urandom_range(1000, 1));
    end else begin
      series_left--;
      if (pick < 70) begin
        wide = ($urandom_range(3) == 0) ? 64'($urandom_range(4)) - 64'd2 : '0;
        it.timestamp = gen_ts + gen_period + wide;
      end else if (pick < 88) begin
        wide = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1) == 1) wide = -wide;
        it.timestamp = gen_ts + gen_period + wide;
      end else begin
        it.timestamp = {$urandom, $urandom};
      end
    end
    gen_ts = it.timestamp;
    return it;
  endfunction

  task automatic send_item(input tdve_pkg::ts_item_t it, input int n_bytes,
                           input logic [79:0] bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      ts_valid <= 1'b0;
      @(posedge clk);
    end
    ts_valid <= 1'b1;
    ts_item <= it;
    do @(posedge clk); while (ts_stall);
    encode_timestamp(it);
    if (n_bytes == USE_PREDICTOR) begin
      foreach (run_bytes[i]) expected_bytes.insert(expected_bytes.size(), run_bytes[i]);
    end else begin
      for (int i = 0; i < n_bytes; i++) begin
        expected_bytes.insert(expected_bytes.size(),
                              tdve_pkg::byte_item_t'{bytes[79-8*i -: 8], 1'(i == n_bytes - 1)});
      end
    end
  endtask

  task automatic wait_for_drain();
    ts_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      byte_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      byte_stall <= 1'b1;
    end else begin
      byte_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    tdve_pkg::byte_item_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_of_run %b",
               byte_item.out_byte, byte_item.last_of_run);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (byte_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, byte_item.out_byte);
          err_count++;
        end
        if (byte_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", want.last_of_run,
                 byte_item.last_of_run);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ts_valid && !ts_stall) || (byte_valid && !byte_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    rows.insert(rows.size(), '{64'sd100, 1'b0, 0, 80'h0});  // no start flag right after reset
    rows.insert(rows.size(), '{64'sd110, 1'b0, 8, 80'h0000_0000_0000_000A_0000});
    rows.insert(rows.size(), '{64'sd120, 1'b0, 1, 80'h0});
    rows.insert(rows.size(), '{64'sd125, 1'b0, 1, 80'h0900_0000_0000_0000_0000});
    rows.insert(rows.size(), '{64'sd145, 1'b0, 1, 80'h1E00_0000_0000_0000_0000});
    rows.insert(rows.size(), '{TS_MAX, 1'b1, 0, 80'h0});  // start flag in the middle of a series
    rows.insert(rows.size(), '{TS_MIN, 1'b0, 8, 80'h0000_0000_0000_0001_0000});
    rows.insert(rows.size(), '{TS_MAX, 1'b0, 1, 80'h0300_0000_0000_0000_0000});
    rows.insert(rows.size(), '{TS_MIN, 1'b0, USE_PREDICTOR, 80'h0});
    rows.insert(rows.size(), '{64'sd0, 1'b1, 0, 80'h0});
    rows.insert(rows.size(), '{64'sd0, 1'b1, 0, 80'h0});
    rows.insert(rows.size(), '{64'sd0, 1'b0, 8, 80'h0});
    // The two largest delta-of-delta magnitudes give full ten-byte varints.
    rows.insert(rows.size(), '{TS_MIN, 1'b0, 10, 80'hFFFF_FFFF_FFFF_FFFF_FF01});
    rows.insert(rows.size(), '{TS_MAX, 1'b0, 10, 80'hFEFF_FFFF_FFFF_FFFF_FF01});
    rows.insert(rows.size(), '{64'(TS_MAX - 65), 1'b0, USE_PREDICTOR, 80'h0});
    rows.insert(rows.size(), '{64'(TS_MAX - 66), 1'b0, USE_PREDICTOR, 80'h0});
    rows.insert(rows.size(), '{64'(TS_MAX - 66), 1'b0, USE_PREDICTOR, 80'h0});
    rows.insert(rows.size(), '{-64'sd5, 1'b1, 0, 80'h0});
    rows.insert(rows.size(), '{-64'sd5, 1'b0, 8, 80'h0});
    rows.insert(rows.size(), '{-64'sd5, 1'b0, 1, 80'h0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct <= 63;

    foreach (rows[r]) begin
      row = rows[r];
      send_item(tdve_pkg::ts_item_t'{row.ts, row.first}, row.n_bytes, row.bytes);
    end
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 63;
        recv_idle_pct <= 16;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end else if (i == 40) begin
        // The sender keeps offering items while the output is held off.
        hold_requests <= hold_requests + 1;
      end
      send_item(random_item(), USE_PREDICTOR, 80'h0);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tdve_pkg.sv
sv/tdve_front.sv
sv/tdve_queue.sv
sv/tdve_back.sv
sv/timestamp_dod_varint_encoder_core.sv
tb/sv/testbench.sv
